@@ design/pvt_pkg.sv @@
// shared types, constants and helper functions for the polygon vertex transform
// no dependencies; imported by every module of the block

package pvt_pkg;

    // pixel range that transformed coordinates saturate to
    localparam int PIXEL_BITS = 16;

    // field widths
    localparam int VERT_W    = 16;
    localparam int COORD_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int SCALE_W   = 16;
    localparam int CENTER_W  = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // datapath widths
    localparam int TRIG_W   = 18;            // sine and cosine, Q1.16
    localparam int Z_W      = 20;            // cordic angle and x/y, Q.16
    localparam int MUL_A_W  = 35;            // rotated coordinate, Q.24
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_OUT = 32;            // fraction bits of the scaled sum
    localparam int CENTER_SHIFT = 24;        // Q.8 centre aligned to Q.32

    // cordic constants, Q.16
    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam logic signed [Z_W-1:0] PI_Q16      = Z_W'(205887);
    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = Z_W'(102944);
    localparam logic signed [Z_W-1:0] TWO_PI_Q16  = Z_W'(411775);
    localparam logic signed [Z_W-1:0] GAIN_Q16    = Z_W'(39797);
    localparam logic signed [Z_W-1:0] ONE_Q16     = Z_W'(65536);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MUL,
        ST_EMIT_SEG,
        ST_EMIT_CLOSE
    } pvt_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_REDUCE,
        CS_ITER,
        CS_FINISH
    } cordic_state_t;

    // arctangent of 2^-i, Q.16
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [STAGE_W-1:0] i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                4'd0:    v = Z_W'(51472);
                4'd1:    v = Z_W'(30385);
                4'd2:    v = Z_W'(16055);
                4'd3:    v = Z_W'(8150);
                4'd4:    v = Z_W'(4091);
                4'd5:    v = Z_W'(2047);
                4'd6:    v = Z_W'(1024);
                4'd7:    v = Z_W'(512);
                4'd8:    v = Z_W'(256);
                4'd9:    v = Z_W'(128);
                4'd10:   v = Z_W'(64);
                4'd11:   v = Z_W'(32);
                4'd12:   v = Z_W'(16);
                4'd13:   v = Z_W'(8);
                4'd14:   v = Z_W'(4);
                4'd15:   v = Z_W'(2);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // add the centre, truncate toward zero to integer pixels, saturate
    function automatic logic [COORD_W-1:0] to_pixel(
        input logic signed [PROD_W-1:0]   scaled,
        input logic signed [CENTER_W-1:0] centre
    );
        logic signed [SUM_W-1:0]          sum;
        logic signed [SUM_W-FRAC_OUT-1:0] q;
        logic signed [63:0]               q64;
        logic signed [63:0]               hi;
        logic signed [63:0]               lo;
        begin
            sum = SUM_W'(scaled)
                + $signed({{(SUM_W-CENTER_W-CENTER_SHIFT){centre[CENTER_W-1]}},
                           centre, {CENTER_SHIFT{1'b0}}});
            q = sum[SUM_W-1:FRAC_OUT];
            if (sum[SUM_W-1] && (sum[FRAC_OUT-1:0] != '0))
                q = q + (SUM_W-FRAC_OUT)'(1);
            q64 = 64'(q);
            hi  = (64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1;
            lo  = -hi - 64'sd1;
            if (q64 > hi)
                q64 = hi;
            if (q64 < lo)
                q64 = lo;
            return q64[COORD_W-1:0];
        end
    endfunction

endpackage

@@ design/pvt_mul.sv @@
// shared signed multiplier with a registered product
// depends on pvt_pkg

module pvt_mul
    import pvt_pkg::*;
(
    input  logic                       clk,
    input  logic signed [MUL_A_W-1:0]  a,
    input  logic signed [MUL_B_W-1:0]  b,
    output logic signed [PROD_W-1:0]   prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ design/pvt_cordic.sv @@
// iterative cordic: one shift-add stage reused for all iterations
// gives sine and cosine of a Q4.12 angle in Q1.16; depends on pvt_pkg

module pvt_cordic
    import pvt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      done,
    output logic signed [TRIG_W-1:0]  sine,
    output logic signed [TRIG_W-1:0]  cosine
);

    cordic_state_t state_reg, state_next;
    logic [STAGE_W-1:0] iter_reg;

    logic signed [Z_W-1:0] x_reg, y_reg, z_reg;
    logic                  neg_reg;
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    logic signed [Z_W-1:0] z_wrap, z_fold;
    logic                  fold;
    logic signed [Z_W-1:0] dx, dy;
    logic signed [Z_W-1:0] xf, yf, xc, yc;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:   if (start) state_next = CS_REDUCE;
            CS_REDUCE: state_next = CS_ITER;
            CS_ITER:   if (iter_reg == STAGE_W'(CORDIC_STAGES - 1)) state_next = CS_FINISH;
            CS_FINISH: state_next = CS_IDLE;
            default:   state_next = CS_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        done = (state_reg == CS_FINISH);
    end

    // range reduction into [-pi, pi], then fold into [-pi/2, pi/2]
    always_comb
    begin
        if (z_reg > PI_Q16)
            z_wrap = z_reg - TWO_PI_Q16;
        else if (z_reg < -PI_Q16)
            z_wrap = z_reg + TWO_PI_Q16;
        else
            z_wrap = z_reg;

        if (z_wrap > HALF_PI_Q16)
        begin
            z_fold = z_wrap - PI_Q16;
            fold   = 1'b1;
        end
        else if (z_wrap < -HALF_PI_Q16)
        begin
            z_fold = z_wrap + PI_Q16;
            fold   = 1'b1;
        end
        else
        begin
            z_fold = z_wrap;
            fold   = 1'b0;
        end
    end

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;

    // undo the fold and clamp to the unit range
    always_comb
    begin
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
        xc = (xf > ONE_Q16) ? ONE_Q16 : ((xf < -ONE_Q16) ? -ONE_Q16 : xf);
        yc = (yf > ONE_Q16) ? ONE_Q16 : ((yf < -ONE_Q16) ? -ONE_Q16 : yf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            iter_reg  <= '0;
            sin_reg   <= '0;
            cos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CS_ITER)
                iter_reg <= iter_reg + STAGE_W'(1);
            else
                iter_reg <= '0;
            if (state_reg == CS_FINISH)
            begin
                sin_reg <= TRIG_W'(yc);
                cos_reg <= TRIG_W'(xc);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_IDLE:
            begin
                z_reg <= Z_W'(angle) <<< 4;
            end
            CS_REDUCE:
            begin
                z_reg   <= z_fold;
                neg_reg <= fold;
                x_reg   <= GAIN_Q16;
                y_reg   <= '0;
            end
            CS_ITER:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_q16(iter_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_q16(iter_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sine   = sin_reg;
    assign cosine = cos_reg;

endmodule

@@ design/polygon_vertex_transform.sv @@
// top level of the polygon vertex transform: sequencer, config registers, output stage
// depends on pvt_pkg, pvt_cordic and pvt_mul
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: vertex_x[15:0] vertex_y[31:16]; s_tlast: last_vertex
//  m_*       out  m_tvalid/m_tready  m_tdata: start_x, start_y, end_x, end_y; m_tlast: final_segment
//  wr_*      in   wr_en              wr_index selects the register, wr_data its value
//
// a vertex is transferred in ST_IDLE, then runs its ST_MUL steps on the shared multiplier
// (four rotate products, two scale products, pixel conversion); the first vertex of a model
// first waits in ST_TRIG for the cordic, and each segment is loaded into the output register
// from ST_EMIT_SEG or ST_EMIT_CLOSE once that register is free
// reset is asynchronous and active low; it clears the model state and sine and cosine
// m_tready low holds the output register; the sequencer waits only to load a new segment

module polygon_vertex_transform
    import pvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*VERT_W-1:0]   s_tdata,   // vertex_x, vertex_y
    input  logic                  s_tlast,   // last_vertex

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [4*COORD_W-1:0]  m_tdata,   // start_x, start_y, end_x, end_y
    output logic                  m_tlast,   // final_segment

    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_W-1:0]      wr_data
);

    // configuration
    logic signed [ANGLE_W-1:0]  angle_reg;
    logic [SCALE_W-1:0]         scale_reg;
    logic signed [CENTER_W-1:0] cx_reg, cy_reg;

    // sequencer
    pvt_state_t state_reg, state_next;
    logic [2:0] step_reg;
    logic       started_reg;   // a model is open
    logic       open_reg;      // the current vertex is not the first of its model

    // current vertex and datapath
    logic signed [VERT_W-1:0]  vx_reg, vy_reg;
    logic                      last_reg;
    logic signed [PROD_W-1:0]  t_reg;
    logic signed [MUL_A_W-1:0] rx_reg, ry_reg;
    logic [COORD_W-1:0]        px_reg, py_reg;
    logic [COORD_W-1:0]        first_x_reg, first_y_reg;
    logic [COORD_W-1:0]        prev_x_reg, prev_y_reg;

    // output register
    logic                  out_valid_reg;
    logic [4*COORD_W-1:0]  out_data_reg;
    logic                  out_last_reg;

    logic accept, out_free, trig_start, trig_done;
    logic load_seg, load_close;
    logic signed [TRIG_W-1:0]  sine, cosine;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    pvt_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (trig_start),
        .angle  (angle_reg),
        .done   (trig_done),
        .sine   (sine),
        .cosine (cosine)
    );

    pvt_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = started_reg ? ST_MUL : ST_TRIG;
            ST_TRIG:
                if (trig_done)
                    state_next = ST_MUL;
            ST_MUL:
                if (step_reg == 3'd7)
                begin
                    if (open_reg)
                        state_next = ST_EMIT_SEG;
                    else if (last_reg)
                        state_next = ST_EMIT_CLOSE;
                    else
                        state_next = ST_IDLE;
                end
            ST_EMIT_SEG:
                if (out_free)
                    state_next = last_reg ? ST_EMIT_CLOSE : ST_IDLE;
            ST_EMIT_CLOSE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        trig_start = (state_reg == ST_IDLE) && s_tvalid && !started_reg;
        load_seg   = (state_reg == ST_EMIT_SEG) && out_free;
        load_close = (state_reg == ST_EMIT_CLOSE) && out_free;
    end

    // multiplier operand schedule: rotate products, then scale products
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = MUL_A_W'(vx_reg); mul_b = cosine; end
            3'd1:    begin mul_a = MUL_A_W'(vy_reg); mul_b = sine;   end
            3'd2:    begin mul_a = MUL_A_W'(vx_reg); mul_b = sine;   end
            3'd3:    begin mul_a = MUL_A_W'(vy_reg); mul_b = cosine; end
            3'd4:    begin mul_a = rx_reg; mul_b = $signed({2'b00, scale_reg}); end
            3'd5:    begin mul_a = ry_reg; mul_b = $signed({2'b00, scale_reg}); end
            default: begin mul_a = '0;     mul_b = '0; end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            scale_reg     <= SCALE_RESET;
            cx_reg        <= '0;
            cy_reg        <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_MUL)
                step_reg <= step_reg + 3'd1;
            else
                step_reg <= '0;

            if (accept)
                started_reg <= 1'b1;
            else if (load_close)
                started_reg <= 1'b0;

            if (load_seg || load_close)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            // first vertex of a model: it opens the outline
            if ((state_reg == ST_MUL) && (step_reg == 3'd7) && !open_reg)
            begin
                first_x_reg <= px_reg;
                first_y_reg <= py_reg;
                prev_x_reg  <= px_reg;
                prev_y_reg  <= py_reg;
            end
            else if (load_seg)
            begin
                prev_x_reg <= px_reg;
                prev_y_reg <= py_reg;
            end

            if (wr_en)
            begin
                case (wr_index)
                    REG_ROTATION_ANGLE: angle_reg <= wr_data[ANGLE_W-1:0];
                    REG_SCALE_FACTOR:   scale_reg <= wr_data[SCALE_W-1:0];
                    REG_CENTER_X:       cx_reg    <= wr_data[CENTER_W-1:0];
                    REG_CENTER_Y:       cy_reg    <= wr_data[CENTER_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vx_reg   <= s_tdata[VERT_W-1:0];
            vy_reg   <= s_tdata[2*VERT_W-1:VERT_W];
            last_reg <= s_tlast;
            open_reg <= started_reg;
        end

        if (state_reg == ST_MUL)
        begin
            case (step_reg)
                3'd1:    t_reg  <= prod;                          // vx*cos
                3'd2:    rx_reg <= MUL_A_W'(t_reg - prod);        // - vy*sin
                3'd3:    t_reg  <= prod;                          // vx*sin
                3'd4:    ry_reg <= MUL_A_W'(t_reg + prod);        // + vy*cos
                3'd5:    px_reg <= to_pixel(prod, cx_reg);
                3'd6:    py_reg <= to_pixel(prod, cy_reg);
                default: ;
            endcase
        end

        if (load_seg)
        begin
            out_data_reg <= {py_reg, px_reg, prev_y_reg, prev_x_reg};
            out_last_reg <= 1'b0;
        end
        else if (load_close)
        begin
            out_data_reg <= {first_y_reg, first_x_reg, py_reg, px_reg};
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ verif/outline_segment_checker.sv @@
// watches the vertex, segment and register channels of polygon_vertex_transform,
// predicts every segment from its own copy of the registers and outline state and compares
// depends on pvt_pkg for port widths, register indexes and the pixel range

module outline_segment_checker
    import pvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [2*VERT_W-1:0]   s_tdata,   // vertex_x, vertex_y
    input  logic                  s_tlast,   // last_vertex

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [4*COORD_W-1:0]  m_tdata,   // start_x, start_y, end_x, end_y
    input  logic                  m_tlast,   // final_segment

    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_W-1:0]      wr_data,

    output int                    error_count,
    output int                    segments_pending
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_pt_t;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               final_seg;
    } segment_t;

    // angles and cordic constants in Q.16
    localparam int PI_Q      = 205887;
    localparam int HALF_PI_Q = 102944;
    localparam int TWO_PI_Q  = 411775;
    localparam int GAIN_Q    = 39797;
    localparam int UNIT_Q    = 65536;

    int arctan_tab [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};

    logic signed [ANGLE_W-1:0]  angle_reg;
    logic        [SCALE_W-1:0]  scale_reg;
    logic signed [CENTER_W-1:0] cx_reg;
    logic signed [CENTER_W-1:0] cy_reg;

    pixel_pt_t first_pt;
    pixel_pt_t prev_pt;
    bit        outline_open;
    int        sin_q;
    int        cos_q;

    segment_t predicted_segments [$];

    // angle reduced to [-pi, pi], folded to [-pi/2, pi/2], then 16 rotation stages
    function automatic void cordic_sin_cos(input logic signed [ANGLE_W-1:0] angle,
                                           output int sin_o, output int cos_o);
        int z;
        int x;
        int y;
        int dx;
        int dy;
        bit flip;
        z = int'(angle) * 16;
        x = GAIN_Q;
        y = 0;
        flip = 1'b0;
        while (z > PI_Q)
            z -= TWO_PI_Q;
        while (z < -PI_Q)
            z += TWO_PI_Q;
        if (z > HALF_PI_Q)
        begin
            z -= PI_Q;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q)
        begin
            z += PI_Q;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_o = (x > UNIT_Q) ? UNIT_Q : (x < -UNIT_Q) ? -UNIT_Q : x;
        sin_o = (y > UNIT_Q) ? UNIT_Q : (y < -UNIT_Q) ? -UNIT_Q : y;
    endfunction

    // exact Q.32 sum, one truncation toward zero, saturation to the pixel range
    function automatic logic [COORD_W-1:0] to_pixel_coord(input longint rotated,
                                                         input logic [SCALE_W-1:0] scale,
                                                         input logic signed [CENTER_W-1:0] centre);
        longint scale_l;
        longint centre_l;
        longint total;
        longint pix;
        longint hi;
        longint lo;
        scale_l  = scale;
        centre_l = centre;
        total = rotated * scale_l + centre_l * (64'sd1 <<< 24);
        pix   = total / (64'sd1 <<< 32);
        hi = (64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (pix > hi)
            pix = hi;
        if (pix < lo)
            pix = lo;
        return pix[COORD_W-1:0];
    endfunction

    task automatic take_vertex(input logic [2*VERT_W-1:0] data, input logic closes);
        logic signed [VERT_W-1:0] vx;
        logic signed [VERT_W-1:0] vy;
        longint rx;
        longint ry;
        pixel_pt_t p;
        vx = data[VERT_W-1:0];
        vy = data[2*VERT_W-1:VERT_W];
        // sine and cosine are latched once per outline
        if (!outline_open)
            cordic_sin_cos(angle_reg, sin_q, cos_q);
        rx = longint'(vx) * cos_q - longint'(vy) * sin_q;
        ry = longint'(vx) * sin_q + longint'(vy) * cos_q;
        p.x = to_pixel_coord(rx, scale_reg, cx_reg);
        p.y = to_pixel_coord(ry, scale_reg, cy_reg);
        if (!outline_open)
        begin
            first_pt = p;
            outline_open = 1'b1;
        end
        else
            predicted_segments.push_back(segment_t'{prev_pt.x, prev_pt.y, p.x, p.y, 1'b0});
        prev_pt = p;
        if (closes)
        begin
            predicted_segments.push_back(segment_t'{p.x, p.y, first_pt.x, first_pt.y, 1'b1});
            outline_open = 1'b0;
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : tracker
        segment_t want;
        if (!rst_n)
        begin
            angle_reg    = '0;
            scale_reg    = SCALE_RESET;
            cx_reg       = '0;
            cy_reg       = '0;
            first_pt     = '0;
            prev_pt      = '0;
            outline_open = 1'b0;
            sin_q        = 0;
            cos_q        = 0;
            predicted_segments.delete();
            segments_pending = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_ROTATION_ANGLE: angle_reg = wr_data[ANGLE_W-1:0];
                    REG_SCALE_FACTOR:   scale_reg = wr_data[SCALE_W-1:0];
                    REG_CENTER_X:       cx_reg    = wr_data[CENTER_W-1:0];
                    REG_CENTER_Y:       cy_reg    = wr_data[CENTER_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (predicted_segments.size() == 0)
                begin
                    $error("segment transfer with nothing predicted: %h last %b",
                           m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = predicted_segments.pop_front();
                    check_field("start_x", want.start_x, m_tdata[15:0]);
                    check_field("start_y", want.start_y, m_tdata[31:16]);
                    check_field("end_x", want.end_x, m_tdata[47:32]);
                    check_field("end_y", want.end_y, m_tdata[63:48]);
                    check_field("final_segment", 16'(want.final_seg), 16'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                take_vertex(s_tdata, s_tlast);
            segments_pending = predicted_segments.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// top of the polygon_vertex_transform testbench: clock, reset, vertex stimulus,
// register programming and segment-side pacing; the verdict comes from the checker's count
// depends on pvt_pkg, polygon_vertex_transform and outline_segment_checker

module testbench;
    import pvt_pkg::*;

    localparam int RANDOM_ITEMS  = 1800;
    // quiet cycles with nothing predicted before registers change or the run ends;
    // covers cordic plus multiplier plus output stage of a vertex that emits nothing
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int RUN_LIMIT     = 3000000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*VERT_W-1:0]   s_tdata  = '0;    // vertex_x, vertex_y
    logic                  s_tlast  = 1'b0;  // last_vertex

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [4*COORD_W-1:0]  m_tdata;          // start_x, start_y, end_x, end_y
    logic                  m_tlast;          // final_segment

    logic                  wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_W-1:0]      wr_data  = '0;

    int error_count;
    int segments_pending;

    int vertices_sent = 0;
    // long output hold-offs asked by the stimulus and carried out by the sink process
    int holds_asked   = 0;
    int holds_served  = 0;
    bit sender_gaps   = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    polygon_vertex_transform u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    outline_segment_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .error_count      (error_count),
        .segments_pending (segments_pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // vertex coordinate: extremes, small values that stay on screen, or any 16 bits
    function automatic logic [VERT_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 16'h7FFF;
        if (r < 8)
            return 16'h8000;
        if (r < 10)
            return 16'h0000;
        if (r < 12)
            return 16'hFFFF;
        if (r < 40)
            return 16'($urandom_range(0, 8192)) - 16'd4096;
        return 16'($urandom());
    endfunction

    // angle: zero, range ends, near the fold points at plus and minus pi/2 and at pi, or any
    function automatic logic [ANGLE_W-1:0] pick_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'h0000;
        if (r < 10)
            return 16'h7FFF;
        if (r < 15)
            return 16'h8000;
        if (r < 20)
            return 16'(6434);
        if (r < 25)
            return 16'(-6434);
        if (r < 30)
            return 16'(12868);
        return 16'($urandom());
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'h0000;
        if (r < 10)
            return 16'hFFFF;
        if (r < 15)
            return 16'(256);
        if (r < 70)
            return 16'($urandom_range(64, 768));
        return 16'($urandom());
    endfunction

    function automatic logic [CENTER_W-1:0] pick_centre();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 24'h7FFFFF;
        if (r < 10)
            return 24'h800000;
        if (r < 15)
            return 24'h000000;
        if (r < 75)
            return 24'($urandom_range(0, 153600)) - 24'd76800;
        return 24'($urandom());
    endfunction

    // offer one vertex and hold it until the transfer
    task automatic send_vertex(input logic [VERT_W-1:0] vx, input logic [VERT_W-1:0] vy,
                               input logic closes);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx};
        s_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_tready);
        vertices_sent++;
    endtask

    // one closed outline: mostly a few vertices, sometimes a single point or a long one
    task automatic send_outline();
        int r;
        int len;
        r = $urandom_range(0, 9);
        len = (r == 0) ? 1 : (r == 1) ? $urandom_range(9, 16) : $urandom_range(2, 6);
        for (int k = 1; k <= len; k++)
            send_vertex(rand_coord(), rand_coord(), k == len);
    endtask

    // stop offering, then wait until every predicted segment has come and the block is quiet
    task automatic settle();
        int quiet;
        quiet = 0;
        s_tvalid <= 1'b0;
        while (quiet < SETTLE_CYCLES)
        begin
            @(posedge clk);
            if (segments_pending == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // back-to-back writes of all four registers, only while the block is idle
    task automatic program_regs(input logic [ANGLE_W-1:0] angle,
                                input logic [SCALE_W-1:0] scale,
                                input logic [CENTER_W-1:0] cx,
                                input logic [CENTER_W-1:0] cy);
        wr_en    <= 1'b1;
        wr_index <= REG_ROTATION_ANGLE;
        wr_data  <= CFG_W'(angle);
        @(posedge clk);
        wr_index <= REG_SCALE_FACTOR;
        wr_data  <= CFG_W'(scale);
        @(posedge clk);
        wr_index <= REG_CENTER_X;
        wr_data  <= CFG_W'(cx);
        @(posedge clk);
        wr_index <= REG_CENTER_Y;
        wr_data  <= CFG_W'(cy);
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    // segment-side pacing: ready runs and stall runs of random length, with long
    // all-ready stretches; a requested hold-off drops ready for a stall run set by LONG_HOLD
    initial
    begin : sink_pacing
        int run_left;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                m_tready <= 1'b0;
                run_left = LONG_HOLD;
            end
            else if (run_left > 0)
                run_left--;
            else if (m_tready)
            begin
                m_tready <= 1'b0;
                run_left = pick_gap();
            end
            else
            begin
                m_tready <= 1'b1;
                run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 20);
            end
        end
    end

    initial
    begin : stimulus
        bit first_phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: one-vertex outline gives a point-to-itself closing segment
        send_vertex(16'h0000, 16'h0000, 1'b1);
        // field extremes at unit scale, no rotation
        send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h8000, 16'h7FFF, 1'b1);
        settle();

        // largest angle, largest scale, centre at both ends: pixel saturation
        program_regs(16'h7FFF, 16'hFFFF, 24'h7FFFFF, 24'h800000);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'hFFFF, 16'h0001, 1'b0);
        send_vertex(16'h0000, 16'h0000, 1'b1);
        send_vertex(16'h8000, 16'h8000, 1'b1);
        settle();

        // most negative angle, zero scale, centre swapped
        program_regs(16'h8000, 16'h0000, 24'h800000, 24'h7FFFFF);
        send_vertex(16'h0001, 16'hFFFF, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h8000, 16'h0000, 1'b1);
        settle();

        // registers changed in the middle of an outline: the new angle must wait for the
        // next outline while scale and centre apply at once
        program_regs(16'(3217), 16'(512), 24'(100 * 256), 24'(-50 * 256));
        send_vertex(16'(256), 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'(256), 1'b0);
        settle();
        program_regs(16'h8000, 16'(128), 24'(-20 * 256), 24'(70 * 256));
        send_vertex(16'(-256), 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'(-256), 1'b1);
        settle();

        // random phases: new registers, a handful of outlines, sometimes an open tail
        // so that the next registers land mid-outline
        vertices_sent = 0;
        first_phase   = 1'b1;
        while (vertices_sent < RANDOM_ITEMS)
        begin
            program_regs(pick_angle(), pick_scale(), pick_centre(), pick_centre());
            sender_gaps = ($urandom_range(0, 3) != 0);
            if (first_phase)
            begin
                // long output hold-off while vertices keep coming, to back up the input
                holds_asked++;
                sender_gaps = 1'b0;
                first_phase = 1'b0;
            end
            repeat ($urandom_range(2, 8)) send_outline();
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) send_vertex(rand_coord(), rand_coord(), 1'b0);
            settle();
        end

        if (error_count == 0)
            $display("** polygon_vertex_transform: PASSED **");
        else
            $display("** polygon_vertex_transform: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("** polygon_vertex_transform: FAILED **");
        $finish;
    end

endmodule
